>>> rtl/core/led_ring_clock_face_core_defines.svh
// Assertion macros for the LED ring clock face core.
// Used by the port checker; the macros expect clk_i and rst_ni in scope.
`ifndef LED_RING_CLOCK_FACE_CORE_DEFINES_SVH
`define LED_RING_CLOCK_FACE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lrcf_pkg.sv
// Shared types and constants of the LED ring clock face core.
// No dependencies; imported by the core and by its port checker.
package lrcf_pkg;

  // Ring geometry.
  localparam int unsigned RING_LEDS       = 60;
  localparam int unsigned ROTATION        = 43;
  localparam int unsigned TICK_SPACING    = RING_LEDS / 12;
  localparam int unsigned QUARTER_SPACING = 3 * TICK_SPACING;
  localparam int unsigned POS_W           = 6;

  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(RING_LEDS - 1);
  localparam logic [POS_W-1:0] LAST_PIXEL = POS_W'((RING_LEDS - 1 + ROTATION) % RING_LEDS);

  // Color limits.
  localparam logic [8:0] HUE_FULL = 9'd360;
  localparam logic [9:0] HUE_HALF = 10'd180;
  localparam logic [9:0] SAT_MAX  = 10'd1000;
  localparam logic [5:0] BRI_MAX  = 6'd50;
  localparam logic [7:0] BRI_TOP  = 8'd200;

  // floor(y / 5) for y below 2^16 as (y * DIV5_MUL) >> DIV5_SHIFT.
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int unsigned DIV5_SHIFT = 18;

  // Configuration register map, word index.
  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_HUE    = 2'd1,
    REG_SAT    = 2'd2,
    REG_BRI    = 2'd3
  } reg_addr_e;

  // One rendered pixel.
  typedef struct packed {
    logic [POS_W-1:0] pixel;
    logic [8:0]       hue;
    logic [9:0]       saturation;
    logic [7:0]       brightness;
    logic             last;
  } pix_t;

  // Hour tick positions: every fifth face position.
  function automatic logic [RING_LEDS-1:0] tick_mask();
    logic [RING_LEDS-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < RING_LEDS; i++) begin
      m[i] = ((i % TICK_SPACING) == 0);
    end
    return m;
  endfunction

  // Quarter hour ticks: every fifteenth face position.
  function automatic logic [RING_LEDS-1:0] quarter_mask();
    logic [RING_LEDS-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < RING_LEDS; i++) begin
      m[i] = ((i % QUARTER_SPACING) == 0);
    end
    return m;
  endfunction

  localparam logic [RING_LEDS-1:0] TICK_MASK    = tick_mask();
  localparam logic [RING_LEDS-1:0] QUARTER_MASK = quarter_mask();

endpackage

>>> rtl/core/led_ring_clock_face_core.sv
// LED ring clock face core: one time of day in, one 60-pixel HSV frame out.
// Depends on lrcf_pkg for constants, the register map and the pixel type.
//
// Usage:
//   The slave stream takes one time of day per transfer. Each time renders a
//   frame of 60 pixel transfers on the master stream, in face order, with
//   tlast on the sixtieth. The pixel field gives the physical LED index.
//   A position counter walks the face; each cycle that the output register can
//   take a pixel, the colour of one position is computed from the latched time
//   and the registers and loaded into the output register. The time is latched
//   first and the first pixel is then loaded into the output register; pixels
//   leave one per cycle while the receiver takes them. The next time is taken
//   in the cycle that issues a frame's last pixel; frames follow back to back.
//   When the receiver stalls, the output register holds its pixel and the
//   counter waits; a new time is not taken until the frame nears its end.
//   The APB port sets enable, base hue, saturation and brightness; write it
//   only while no frame is in flight. pready is always high.
//   Reset empties the output register, drops any frame in flight and loads
//   the register reset values (disabled, hue 120, saturation 1000,
//   brightness 0).
module led_ring_clock_face_core
  import lrcf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Time of day in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] hour, [10:5] minute, [16:11] second, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  // Pixels out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] pixel, [14:6] hue, [24:15] saturation, [32:25] brightness, [39:33] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic       enable_q;
  logic [8:0] base_hue_q;
  logic [9:0] base_sat_q;
  logic [5:0] base_bri_q;

  reg_addr_e  reg_sel;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_addr_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      base_hue_q <= 9'd120;
      base_sat_q <= 10'd1000;
      base_bri_q <= 6'd0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ENABLE: enable_q   <= pwdata[0];
        REG_HUE:    base_hue_q <= pwdata[8:0];
        REG_SAT:    base_sat_q <= pwdata[9:0];
        REG_BRI:    base_bri_q <= pwdata[5:0];
        default:    enable_q   <= enable_q;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_sel)
      REG_ENABLE: prdata = {31'd0, enable_q};
      REG_HUE:    prdata = {23'd0, base_hue_q};
      REG_SAT:    prdata = {22'd0, base_sat_q};
      REG_BRI:    prdata = {26'd0, base_bri_q};
      default:    prdata = 32'd0;
    endcase
  end

  // Frame control: busy while positions of the latched time remain.
  logic             busy_q;
  logic [POS_W-1:0] pos_q;
  logic             out_valid_q;
  logic             issue;
  logic             in_xfer;

  assign issue         = busy_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !busy_q || (issue && (pos_q == LAST_POS));
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Time decoding at the input: wrap minute and second, place the hour hand.
  logic [4:0]       hr_in;
  logic [5:0]       mn_raw;
  logic [5:0]       sc_raw;
  logic [POS_W-1:0] mn_in;
  logic [POS_W-1:0] sc_in;
  logic [2:0]       mn_div12;
  logic [7:0]       hand_sum;
  logic [POS_W-1:0] hand_in;

  always_comb begin
    hr_in  = s_axis_tdata[4:0];
    mn_raw = s_axis_tdata[10:5];
    sc_raw = s_axis_tdata[16:11];
    mn_in  = (mn_raw >= POS_W'(RING_LEDS)) ? mn_raw - POS_W'(RING_LEDS) : mn_raw;
    sc_in  = (sc_raw >= POS_W'(RING_LEDS)) ? sc_raw - POS_W'(RING_LEDS) : sc_raw;
    if (mn_in >= 6'd48) begin
      mn_div12 = 3'd4;
    end else if (mn_in >= 6'd36) begin
      mn_div12 = 3'd3;
    end else if (mn_in >= 6'd24) begin
      mn_div12 = 3'd2;
    end else if (mn_in >= 6'd12) begin
      mn_div12 = 3'd1;
    end else begin
      mn_div12 = 3'd0;
    end
    // Hour times five plus minute over twelve, at most 159.
    hand_sum = ({3'd0, hr_in} << 2) + {3'd0, hr_in} + {5'd0, mn_div12};
    if (hand_sum >= 8'(2 * RING_LEDS)) begin
      hand_in = POS_W'(hand_sum - 8'(2 * RING_LEDS));
    end else if (hand_sum >= 8'(RING_LEDS)) begin
      hand_in = POS_W'(hand_sum - 8'(RING_LEDS));
    end else begin
      hand_in = POS_W'(hand_sum);
    end
  end

  // Latched time of the frame in flight.
  logic [POS_W-1:0] mn_q;
  logic [POS_W-1:0] sc_q;
  logic [POS_W-1:0] hand_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mn_q   <= mn_in;
      sc_q   <= sc_in;
      hand_q <= hand_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else if (in_xfer) begin
      busy_q <= 1'b1;
      pos_q  <= '0;
    end else if (issue) begin
      if (pos_q == LAST_POS) begin
        busy_q <= 1'b0;
        pos_q  <= '0;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // Base colour with the register values brought into range.
  logic [8:0]  h0;
  logic [9:0]  h_opp_sum;
  logic [8:0]  h_opp;
  logic [9:0]  s0;
  logic [5:0]  b0;
  logic [11:0] s_x4;
  logic [27:0] s_div_prod;
  logic [9:0]  s_tick;

  always_comb begin
    h0         = (base_hue_q >= HUE_FULL) ? base_hue_q - HUE_FULL : base_hue_q;
    h_opp_sum  = {1'b0, h0} + HUE_HALF;
    h_opp      = (h_opp_sum >= {1'b0, HUE_FULL}) ? 9'(h_opp_sum - {1'b0, HUE_FULL})
                                                 : 9'(h_opp_sum);
    s0         = (base_sat_q > SAT_MAX) ? SAT_MAX : base_sat_q;
    b0         = (base_bri_q > BRI_MAX) ? BRI_MAX : base_bri_q;
    // Four fifths of the saturation, rounded down.
    s_x4       = {s0, 2'b00};
    s_div_prod = s_x4 * DIV5_MUL;
    s_tick     = 10'(s_div_prod >> DIV5_SHIFT);
  end

  // Colour of the current face position.
  logic       on_sec;
  logic       on_min;
  logic       tick_on;
  logic [6:0] d_hour;
  logic [6:0] d_min;
  logic       near_hour;
  logic       near_min;
  logic [6:0] rot_sum;
  pix_t       pix_d;

  always_comb begin
    on_sec  = (pos_q == sc_q);
    on_min  = (pos_q == mn_q);
    tick_on = TICK_MASK[pos_q] && !on_sec && !on_min;

    // Distance from the hands, modulo the ring.
    d_hour = {1'b0, pos_q} - {1'b0, hand_q};
    if (d_hour[6]) begin
      d_hour = d_hour + 7'(RING_LEDS);
    end
    d_min = {1'b0, pos_q} - {1'b0, mn_q};
    if (d_min[6]) begin
      d_min = d_min + 7'(RING_LEDS);
    end
    near_hour = (d_hour <= 7'd2) || (d_hour >= 7'(RING_LEDS - 2));
    near_min  = (d_min <= 7'd1) || (d_min >= 7'(RING_LEDS - 1));

    rot_sum = {1'b0, pos_q} + 7'(ROTATION);
    if (rot_sum >= 7'(RING_LEDS)) begin
      rot_sum = rot_sum - 7'(RING_LEDS);
    end
    pix_d.pixel = POS_W'(rot_sum);
    pix_d.last  = (pos_q == LAST_POS);

    if (!enable_q) begin
      pix_d.hue        = 9'd0;
      pix_d.saturation = 10'd0;
      pix_d.brightness = 8'd0;
    end else if (on_sec) begin
      // Second hand: complementary hue at base saturation and brightness.
      pix_d.hue        = h_opp;
      pix_d.saturation = s0;
      pix_d.brightness = {2'b00, b0};
    end else begin
      pix_d.hue        = h0;
      pix_d.saturation = tick_on ? s_tick : s0;
      if (near_hour || near_min) begin
        pix_d.brightness = 8'd0;
      end else if (tick_on) begin
        pix_d.brightness = QUARTER_MASK[pos_q] ? {b0, 2'b00} : {1'b0, b0, 1'b0};
      end else begin
        pix_d.brightness = {2'b00, b0};
      end
    end
  end

  // Output register.
  pix_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (issue) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_q <= pix_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {7'd0, out_q.brightness, out_q.saturation, out_q.hue, out_q.pixel};

endmodule

>>> rtl/core/lrcf_checker.sv
// Port checker for the LED ring clock face core, attached by bind.
// Depends on lrcf_pkg and on led_ring_clock_face_core_defines.svh.
`include "led_ring_clock_face_core_defines.svh"

module lrcf_checker
  import lrcf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled pixel transfer stays offered and unchanged.
  `LRC_ASSERT_NEXT(a_out_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "pixel dropped while stalled")
  `LRC_ASSERT_NEXT(a_out_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "pixel changed while stalled")

  // The frame end mark sits on the LED of the last face position and nowhere else.
  `LRC_ASSERT_NOW(a_last_pixel, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[5:0] == LAST_PIXEL), "frame end mark on the wrong LED")

  // Saturation and brightness never leave their ranges.
  `LRC_ASSERT_NOW(a_color_range, m_axis_tvalid, (m_axis_tdata[24:15] <= SAT_MAX) && (m_axis_tdata[32:25] <= BRI_TOP), "colour out of range")

endmodule

bind led_ring_clock_face_core lrcf_checker u_lrcf_checker (.*);
